@@ hdl/csi_pkg.sv @@
// Package with constants and the CORDIC angle table for the circle-segment test.
`timescale 1ns / 1ps
package csi_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 34;   // CORDIC x/y/z width
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    // Rotation angle of each micro-rotation, in units of 2^-32 turn.
    function automatic logic signed [CW-1:0] atan_turn(input int i);
        logic signed [CW-1:0] v;
        begin
            case (i)
                0: v = 34'sd536870912;
                1: v = 34'sd316933406;
                2: v = 34'sd167458907;
                3: v = 34'sd85004756;
                4: v = 34'sd42667331;
                5: v = 34'sd21354465;
                6: v = 34'sd10679838;
                7: v = 34'sd5340245;
                8: v = 34'sd2670163;
                9: v = 34'sd1335087;
                10: v = 34'sd667544;
                11: v = 34'sd333772;
                12: v = 34'sd166886;
                13: v = 34'sd83443;
                14: v = 34'sd41722;
                15: v = 34'sd20861;
                16: v = 34'sd10430;
                17: v = 34'sd5215;
                18: v = 34'sd2608;
                19: v = 34'sd1304;
                20: v = 34'sd652;
                21: v = 34'sd326;
                22: v = 34'sd163;
                23: v = 34'sd81;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ hdl/circle_segment_intersect.sv @@
// Pipelined circle versus line-segment intersection test.
//
// One input word carries a circle (center, radius, Q8.8 scale) and a segment
// (start, binary angle, length, Q8.8 scale); one output word carries hit.
// Both channels use valid/ready. The pipeline takes a new word in every
// cycle while its output side moves, so sustained throughput is one word
// per clock.
// From input acceptance to output valid, a word passes the setup stages,
// 24 CORDIC micro-rotation stages (one per stage), then the rounding,
// the projection products, T and P, the magnitudes, the partial squares,
// the square sums and the final compare.
// The CORDIC chain sets the depth; wide squares are split into partial
// products of about 20x20 bits so no stage holds a multiplier much above
// 32x32 bits or more than one wide add and compare.
// When the receiver stalls, the output word holds, while earlier stages keep
// moving into empty stages ahead of them, so bubbles are squeezed out. Ready
// drops only when every stage is full and the output is stalled, and it
// follows out_ready in the same cycle. A stall loses and repeats nothing.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module circle_segment_intersect (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic signed [31:0] circle_x,
    input  logic signed [31:0] circle_y,
    input  logic [30:0] circle_rad,
    input  logic [15:0] circle_scale,
    input  logic signed [31:0] line_x,
    input  logic signed [31:0] line_y,
    input  logic [15:0] line_angle,
    input  logic [30:0] line_length,
    input  logic [15:0] line_scale,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit
);
    import csi_pkg::*;

    localparam int NS = CORDIC_STEPS;
    localparam int NV = NS + 10;  // valid bits: setup 3, cordic NS, tail 7

    // Valid chain and per-stage advance enables (bubble collapsing).
    logic [NV-1:0] v_reg;
    logic [NV:1]   adv;

    always_comb
    begin
        adv[NV] = out_ready || !v_reg[NV-1];
        for (int k = NV - 1; k >= 1; k--)
        begin
            adv[k] = adv[k+1] || !v_reg[k-1];
        end
    end
    // adv[k+1] lets stage k load from stage k-1 (stage -1 is the input).
    assign in_ready  = adv[1];
    assign out_valid = v_reg[NV-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NV; k++)
            begin
                if (adv[k+1])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // ---------------- Setup stage 0: differences, scale products, angle.
    logic signed [32:0] dx0_reg, dy0_reg;
    logic [46:0] rp0_reg, lp0_reg;
    logic [1:0]  q0_reg;
    logic signed [CW-1:0] z0_reg;

    logic [31:0] a_w;
    logic [1:0]  q_w;
    logic [31:0] ru_w;

    always_comb
    begin
        a_w  = {line_angle[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
        q_w  = 2'((a_w + 32'h2000_0000) >> 30);
        ru_w = a_w - {q_w, 30'd0};
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            dx0_reg <= 33'(circle_x) - 33'(line_x);
            dy0_reg <= 33'(circle_y) - 33'(line_y);
            rp0_reg <= 47'(circle_rad) * 47'(circle_scale);
            lp0_reg <= 47'(line_length) * 47'(line_scale);
            q0_reg  <= q_w;
            z0_reg  <= CW'(signed'(ru_w));
        end
    end

    // Stage 1: round scaled lengths. Stage 2: partial products of the
    // radius square, summed in the first CORDIC stage.
    logic signed [32:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    logic [39:0] r1_reg, l1_reg, r2_reg, l2_reg;
    logic [39:0] rhh2_reg, rhl2_reg, rll2_reg;
    logic [1:0]  q1_reg, q2_reg;
    logic signed [CW-1:0] z1_reg, z2_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            dx1_reg <= dx0_reg;
            dy1_reg <= dy0_reg;
            r1_reg  <= 40'((rp0_reg + 47'd128) >> 8);
            l1_reg  <= 40'((lp0_reg + 47'd128) >> 8);
            q1_reg  <= q0_reg;
            z1_reg  <= z0_reg;
        end
        if (adv[3])
        begin
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            r2_reg   <= r1_reg;
            l2_reg   <= l1_reg;
            rhh2_reg <= 40'(r1_reg[39:20]) * 40'(r1_reg[39:20]);
            rhl2_reg <= 40'(r1_reg[39:20]) * 40'(r1_reg[19:0]);
            rll2_reg <= 40'(r1_reg[19:0]) * 40'(r1_reg[19:0]);
            q2_reg   <= q1_reg;
            z2_reg   <= z1_reg;
        end
    end

    // ---------------- CORDIC: one micro-rotation per stage.
    logic signed [CW-1:0] cx_reg [NS];
    logic signed [CW-1:0] cy_reg [NS];
    logic signed [CW-1:0] cz_reg [NS];
    logic signed [32:0]   cdx_reg [NS];
    logic signed [32:0]   cdy_reg [NS];
    logic [39:0]          cr_reg [NS];
    logic [39:0]          cl_reg [NS];
    logic [79:0]          crr_reg [NS];
    logic [1:0]           cq_reg [NS];

    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_cordic
            logic signed [CW-1:0] xi, yi, zi;
            logic signed [32:0]   dxi, dyi;
            logic [39:0]          ri, li;
            logic [79:0]          rri;
            logic [1:0]           qi;
            if (g == 0)
            begin : g_first
                assign xi  = CORDIC_GAIN;
                assign yi  = '0;
                assign zi  = z2_reg;
                assign dxi = dx2_reg;
                assign dyi = dy2_reg;
                assign ri  = r2_reg;
                assign li  = l2_reg;
                // Radius squared from its high and low halves.
                assign rri = (80'(rhh2_reg) << 40) + (80'(rhl2_reg) << 21) +
                             80'(rll2_reg);
                assign qi  = q2_reg;
            end
            else
            begin : g_next
                assign xi  = cx_reg[g-1];
                assign yi  = cy_reg[g-1];
                assign zi  = cz_reg[g-1];
                assign dxi = cdx_reg[g-1];
                assign dyi = cdy_reg[g-1];
                assign ri  = cr_reg[g-1];
                assign li  = cl_reg[g-1];
                assign rri = crr_reg[g-1];
                assign qi  = cq_reg[g-1];
            end
            always_ff @(posedge clk)
            begin
                if (adv[g+4])
                begin
                    if (!zi[CW-1])
                    begin
                        cx_reg[g] <= xi - (yi >>> g);
                        cy_reg[g] <= yi + (xi >>> g);
                        cz_reg[g] <= zi - atan_turn(g);
                    end
                    else
                    begin
                        cx_reg[g] <= xi + (yi >>> g);
                        cy_reg[g] <= yi - (xi >>> g);
                        cz_reg[g] <= zi + atan_turn(g);
                    end
                    cdx_reg[g] <= dxi;
                    cdy_reg[g] <= dyi;
                    cr_reg[g]  <= ri;
                    cl_reg[g]  <= li;
                    crr_reg[g] <= rri;
                    cq_reg[g]  <= qi;
                end
            end
        end
    endgenerate

    // ---------------- Tail stage A: quadrant fold and Q24 rounding.
    localparam int TA = NS + 3;
    logic signed [CW-1:0] xf, yf, cf, sf;
    logic signed [27:0] ca_reg, sa_reg;
    logic signed [32:0] dxa_reg, dya_reg;
    logic [39:0] ra_reg, la_reg;
    logic [79:0] rra_reg;

    always_comb
    begin
        xf = cx_reg[NS-1];
        yf = cy_reg[NS-1];
        case (cq_reg[NS-1])
            2'd0:    begin cf = xf;  sf = yf;  end
            2'd1:    begin cf = -yf; sf = xf;  end
            2'd2:    begin cf = -xf; sf = -yf; end
            default: begin cf = yf;  sf = -xf; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[TA+1])
        begin
            ca_reg  <= 28'((cf + CW'(32)) >>> 6);
            sa_reg  <= 28'((sf + CW'(32)) >>> 6);
            dxa_reg <= cdx_reg[NS-1];
            dya_reg <= cdy_reg[NS-1];
            ra_reg  <= cr_reg[NS-1];
            la_reg  <= cl_reg[NS-1];
            rra_reg <= crr_reg[NS-1];
        end
    end

    // Tail stage B: the four projection products.
    logic signed [60:0] pcx_reg, psy_reg, pcy_reg, psx_reg;
    logic [39:0] rb_reg, lb_reg;
    logic [79:0] rrb_reg;

    always_ff @(posedge clk)
    begin
        if (adv[TA+2])
        begin
            pcx_reg <= 61'(ca_reg) * 61'(dxa_reg);
            psy_reg <= 61'(sa_reg) * 61'(dya_reg);
            pcy_reg <= 61'(ca_reg) * 61'(dya_reg);
            psx_reg <= 61'(sa_reg) * 61'(dxa_reg);
            rb_reg  <= ra_reg;
            lb_reg  <= la_reg;
            rrb_reg <= rra_reg;
        end
    end

    // Tail stage C: T and P with rounding.
    logic signed [61:0] tsum, psum;
    logic signed [37:0] tc_reg, pc_reg;
    logic [39:0] rc_reg, lc_reg;
    logic [79:0] rrc_reg;

    always_comb
    begin
        tsum = 62'(pcx_reg) + 62'(psy_reg) + 62'sd8388608;
        psum = 62'(pcy_reg) - 62'(psx_reg) + 62'sd8388608;
    end

    always_ff @(posedge clk)
    begin
        if (adv[TA+3])
        begin
            tc_reg  <= 38'(tsum >>> 24);
            pc_reg  <= 38'(psum >>> 24);
            rc_reg  <= rb_reg;
            lc_reg  <= lb_reg;
            rrc_reg <= rrb_reg;
        end
    end

    // Tail stage D: magnitudes, segment tests, end offset.
    logic [37:0] pmag_d_reg, emag_d_reg;
    logic        dec_d_reg, dec_val_d_reg;
    logic [79:0] rrd_reg;
    logic signed [41:0] e_w;
    logic [37:0] pmag_w;
    logic        nonzero_len;

    always_comb
    begin
        pmag_w      = pc_reg[37] ? 38'(-pc_reg) : 38'(pc_reg);
        e_w         = (tc_reg > 0) ? (42'(tc_reg) - 42'(signed'({1'b0, lc_reg})))
                                   : 42'(tc_reg);
        nonzero_len = (lc_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv[TA+4])
        begin
            pmag_d_reg    <= pmag_w;
            emag_d_reg    <= 38'(e_w[41] ? -e_w : e_w);
            dec_d_reg     <= nonzero_len && ((40'(pmag_w) > rc_reg) ||
                             (!tc_reg[37] && (40'(tc_reg) <= lc_reg)));
            dec_val_d_reg <= nonzero_len && !(40'(pmag_w) > rc_reg);
            rrd_reg       <= rrc_reg;
        end
    end

    // Tail stage E: partial products of both squares, 19-bit halves.
    logic [37:0] ehh_e_reg, ehl_e_reg, ell_e_reg;
    logic [37:0] phh_e_reg, phl_e_reg, pll_e_reg;
    logic [79:0] rre_reg;
    logic        dec_e_reg, dec_val_e_reg;

    always_ff @(posedge clk)
    begin
        if (adv[TA+5])
        begin
            ehh_e_reg     <= 38'(emag_d_reg[37:19]) * 38'(emag_d_reg[37:19]);
            ehl_e_reg     <= 38'(emag_d_reg[37:19]) * 38'(emag_d_reg[18:0]);
            ell_e_reg     <= 38'(emag_d_reg[18:0]) * 38'(emag_d_reg[18:0]);
            phh_e_reg     <= 38'(pmag_d_reg[37:19]) * 38'(pmag_d_reg[37:19]);
            phl_e_reg     <= 38'(pmag_d_reg[37:19]) * 38'(pmag_d_reg[18:0]);
            pll_e_reg     <= 38'(pmag_d_reg[18:0]) * 38'(pmag_d_reg[18:0]);
            rre_reg       <= rrd_reg;
            dec_e_reg     <= dec_d_reg;
            dec_val_e_reg <= dec_val_d_reg;
        end
    end

    // Tail stage F: the two squares from their partial products.
    logic [75:0] ee_reg, pp_reg;
    logic [79:0] rrf_reg;
    logic        dec_f_reg, dec_val_f_reg;

    always_ff @(posedge clk)
    begin
        if (adv[TA+6])
        begin
            ee_reg        <= (76'(ehh_e_reg) << 38) + (76'(ehl_e_reg) << 20) +
                             76'(ell_e_reg);
            pp_reg        <= (76'(phh_e_reg) << 38) + (76'(phl_e_reg) << 20) +
                             76'(pll_e_reg);
            rrf_reg       <= rre_reg;
            dec_f_reg     <= dec_e_reg;
            dec_val_f_reg <= dec_val_e_reg;
        end
    end

    // Tail stage G: sum of squares against radius squared, unless the segment tests decided.
    logic hit_reg;

    always_ff @(posedge clk)
    begin
        if (adv[TA+7])
        begin
            if (dec_f_reg)
            begin
                hit_reg <= dec_val_f_reg;
            end
            else
            begin
                hit_reg <= (80'(ee_reg) + 80'(pp_reg)) <= rrf_reg;
            end
        end
    end

    assign hit = hit_reg;

    // A stalled output word holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit))
        else $error("output word changed while stalled");

    // Input is always taken when the output stage is empty.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[NV-1] |-> in_ready)
        else $error("ready low with empty output stage");

    // An accepted word enters the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v_reg[0])
        else $error("accepted word lost at entry");

endmodule

@@ sim/tb_circle_segment_intersect.sv @@
// Self-checking testbench for the pipelined circle versus segment intersection test.
`timescale 1ns / 1ps
module tb_circle_segment_intersect;
    import csi_pkg::*;

    localparam int LATENCY     = 33;
    localparam int STALL_LIMIT = 20000;
    localparam int RAND_WORDS  = 1950;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        cr;
        logic [15:0]        cs;
        logic signed [31:0] lx;
        logic signed [31:0] ly;
        logic [15:0]        la;
        logic [30:0]        ll;
        logic [15:0]        ls;
    } pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] circle_x = '0;
    logic signed [31:0] circle_y = '0;
    logic [30:0] circle_rad = '0;
    logic [15:0] circle_scale = '0;
    logic signed [31:0] line_x = '0;
    logic signed [31:0] line_y = '0;
    logic [15:0] line_angle = '0;
    logic [30:0] line_length = '0;
    logic [15:0] line_scale = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic hit;

    pair_t pending_pairs[$];
    logic  expected_hits[$];
    int    send_idle_pct = 35;
    int    recv_idle_pct = 54;
    int    quiet_cycles = 0;
    int    error_count = 0;

    always #6 clk = ~clk;

    circle_segment_intersect DUT (.*);

    // Unit direction vector in Q24 from a binary angle, CORDIC in Q30.
    function automatic void unit_vector(input logic [15:0] angle,
                                        output longint cq, output longint sq);
        logic [31:0] a;
        logic [1:0]  quad;
        logic [31:0] resid;
        longint x, y, z, nx, c, s;
        a = {angle, 16'h0};
        quad = 2'((a + 32'h2000_0000) >> 30);
        resid = a - (32'(quad) << 30);
        z = longint'($signed(resid));
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= longint'(atan_turn(i));
            end
            else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += longint'(atan_turn(i));
            end
            x = nx;
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        cq = (c + 32) >>> 6;
        sq = (s + 32) >>> 6;
    endfunction

    // Whether the circle touches the segment, compared on exact squares.
    function automatic logic touches(input pair_t w);
        longint dx, dy, c, s, t, p, e, r, len;
        logic signed [127:0] ee, pp, rr;
        dx = longint'($signed(w.cx)) - longint'($signed(w.lx));
        dy = longint'($signed(w.cy)) - longint'($signed(w.ly));
        r = (longint'(w.cr) * longint'(w.cs) + 128) >>> 8;
        len = (longint'(w.ll) * longint'(w.ls) + 128) >>> 8;
        unit_vector(w.la, c, s);
        t = (c * dx + s * dy + (64'sd1 <<< 23)) >>> 24;
        p = (c * dy - s * dx + (64'sd1 <<< 23)) >>> 24;
        if (len != 0) begin
            if ((p < 0 ? -p : p) > r)
                return 1'b0;
            if (t >= 0 && t <= len)
                return 1'b1;
        end
        e = (t > 0) ? t - len : t;
        ee = 128'(e) * 128'(e);
        pp = 128'(p) * 128'(p);
        rr = 128'(r) * 128'(r);
        return (ee + pp) <= rr;
    endfunction

    function automatic pair_t random_pair();
        pair_t w;
        int    span;
        logic [255:0] rnd;
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom};
        w = rnd[$bits(pair_t)-1:0];
        // Mostly near-miss geometry so both outcomes appear often.
        if ($urandom_range(0, 9) < 7) begin
            span = 1 << $urandom_range(8, 30);
            w.lx = w.cx + $signed(32'($urandom_range(0, span))) - span / 2;
            w.ly = w.cy + $signed(32'($urandom_range(0, span))) - span / 2;
            w.cr = 31'($urandom_range(0, span));
            w.ll = 31'($urandom_range(0, span));
            w.cs = 16'($urandom_range(0, 512));
            w.ls = 16'($urandom_range(0, 512));
            if ($urandom_range(0, 7) == 0) w.ls = '0;
            if ($urandom_range(0, 7) == 0) w.cs = '0;
        end
        return w;
    endfunction

    // Driver: presents queued words, holding each until it is taken.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                expected_hits.push_back(touches(pair_t'({circle_x, circle_y,
                    circle_rad, circle_scale, line_x, line_y, line_angle,
                    line_length, line_scale})));
            end
            if (!in_valid || in_ready) begin
                if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    pair_t w;
                    w = pending_pairs.pop_front();
                    in_valid <= 1'b1;
                    {circle_x, circle_y, circle_rad, circle_scale, line_x, line_y,
                     line_angle, line_length, line_scale} <= w;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: checks each result word against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual hit=%0b",
                         $time, hit);
                error_count++;
            end
            else begin
                logic want;
                want = expected_hits.pop_front();
                if (hit !== want) begin
                    $display("%0t: hit mismatch, expected %0b, actual %0b",
                             $time, want, hit);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        pair_t w;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words: field extremes, zero scales, zero length, all quadrants.
        w = '0;
        pending_pairs.push_back(w);
        w = '1;
        pending_pairs.push_back(w);
        w = '0; w.cx = 32'sh7FFF_FFFF; w.cy = 32'sh7FFF_FFFF;
        w.lx = 32'sh8000_0000; w.ly = 32'sh8000_0000; w.la = 16'h2000;
        w.cr = '1; w.cs = '1; w.ll = '1; w.ls = '1;
        pending_pairs.push_back(w);
        w.la = 16'hA000;
        pending_pairs.push_back(w);
        for (int q = 0; q < 8; q++) begin
            w = '0; w.cx = 32'sd10 << 16; w.cr = 31'd1 << 16; w.cs = 16'h0100;
            w.ll = 31'd20 << 16; w.ls = 16'h0100; w.la = 16'(q * 16'h2000);
            pending_pairs.push_back(w);
        end
        w = '0; w.cx = 32'sd3 << 16; w.cr = 31'd2 << 16; w.cs = 16'h0100;
        w.ls = 16'h0000; w.ll = 31'd5 << 16;
        pending_pairs.push_back(w);
        w.cr = 31'd4 << 16;
        pending_pairs.push_back(w);
        w.cs = 16'h0000;
        pending_pairs.push_back(w);
        w = '0; w.cx = -(32'sd2 << 16); w.cr = 31'd3 << 16; w.cs = 16'h0100;
        w.ll = 31'd4 << 16; w.ls = 16'h0100;
        pending_pairs.push_back(w);
        w.cx = 32'sd6 << 16;
        pending_pairs.push_back(w);
        w.cx = 32'sd8 << 16;
        pending_pairs.push_back(w);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 54 : 0;
            recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 35 : 0;
            for (int i = 0; i < RAND_WORDS / 3; i++)
                pending_pairs.push_back(random_pair());
            while (pending_pairs.size() > 0 || in_valid)
                @(posedge clk);
        end
        while (expected_hits.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
hdl/csi_pkg.sv
hdl/circle_segment_intersect.sv
sim/tb_circle_segment_intersect.sv
